// ===== rtl/core/bdq_pkg.sv =====
// Shared constants and types for the bounded deque with delete-by-value.
package bdq_pkg;

    localparam int DEPTH    = 16;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int DATA_W   = 32;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_BACK  = 3'd0,
        MODE_PUSH_FRONT = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_DELETE     = 3'd4,
        MODE_MAX        = 3'd5
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [DATA_W-1:0] operand;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        t_status                  status;
        logic [OCC_W-1:0]         occupancy;
    } t_out_item;

    // What a cell loads on the next edge.
    typedef enum logic [1:0] {
        SEL_HOLD,
        SEL_OPERAND,
        SEL_LEFT,
        SEL_RIGHT
    } t_cell_sel;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAX,
        S_DEL,
        S_FIN
    } t_state;

endpackage

// ===== rtl/core/bdq_cell.sv =====
// One deque cell: holds an entry and takes it from a neighbour or the operand.
module bdq_cell (
    input  logic                              i_clk,
    input  bdq_pkg::t_cell_sel                i_sel,
    input  logic signed [bdq_pkg::DATA_W-1:0] i_left,
    input  logic signed [bdq_pkg::DATA_W-1:0] i_right,
    input  logic signed [bdq_pkg::DATA_W-1:0] i_operand,
    output logic signed [bdq_pkg::DATA_W-1:0] o_value,
    output logic                              o_match
);
    import bdq_pkg::*;

    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] n_value;

    always_comb begin
        unique case (i_sel)
            SEL_OPERAND: n_value = i_operand;
            SEL_LEFT:    n_value = i_left;
            SEL_RIGHT:   n_value = i_right;
            default:     n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_match = (r_value == i_operand);

endmodule

// ===== rtl/core/bounded_deque_with_delete.sv =====
// Top level of the bounded deque: cell row, sequencer, occupancy and result register.
//
// Usage. Input transactions carry a mode and a signed operand on i_in_data; they are
// taken at an edge where i_in_valid is high and o_in_stall is low. Every input
// transaction yields exactly one output transaction on o_out_data (data, status,
// occupancy after the operation), taken when o_out_valid is high and i_out_stall low.
// The entries sit in a row of DEPTH cells, the front entry in cell 0. Pushes and pops
// move the whole row by one place, write one cell, or only lower the count, so their
// result appears in the cycle after acceptance. Maximum rotates the row once round,
// one cell a cycle, comparing the entry leaving cell 0 with a running maximum; its
// result is registered from S_FIN. Delete compares every cell with the operand at
// once and closes up the lowest matching entry each cycle until none is left; its
// result is also registered from S_FIN. Operations on an empty store, and unused
// modes, are answered straight from the idle state. One operation is in progress at
// a time: the next transaction is taken once the row is idle and the output register
// is empty or being read at that edge. A stalled receiver holds the output register;
// a finished scan then waits until the register is free. Reset empties the store and
// clears the sequencer; cell contents are not cleared.
module bounded_deque_with_delete (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bdq_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bdq_pkg::t_out_item o_out_data
);
    import bdq_pkg::*;

    t_state                   r_state;
    t_state                   n_state;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic [IDX_W-1:0]         r_step;
    logic [IDX_W-1:0]         n_step;
    logic signed [DATA_W-1:0] r_operand;
    logic signed [DATA_W-1:0] r_acc;
    logic signed [DATA_W-1:0] n_acc;
    logic                     r_out_valid;
    logic                     n_out_valid;
    t_out_item                r_out;
    t_out_item                n_out;

    logic signed [DATA_W-1:0] w_value [DEPTH];
    logic                     w_match [DEPTH];
    t_cell_sel                w_sel   [DEPTH];
    logic                     w_prefix[DEPTH];
    logic                     w_any_del;
    logic signed [DATA_W-1:0] w_cell_operand;
    logic                     w_accept;
    logic                     w_out_free;
    logic                     w_empty;
    logic                     w_full;
    logic                     w_scan_last;
    t_mode                    w_mode;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE) || !w_out_free;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_empty     = (r_count == '0);
    assign w_full      = (r_count == CNT_W'(DEPTH));
    assign w_scan_last = (r_step == IDX_W'(DEPTH - 1));
    assign w_mode      = t_mode'(i_in_data.mode);

    // In the idle state the operand comes straight from the input; during a delete
    // scan every cell compares against the captured one.
    assign w_cell_operand = (r_state == S_IDLE) ? i_in_data.operand : r_operand;

    // The row of cells. Cell 0 holds the front; the ends are joined so that the row
    // can rotate round for the maximum scan.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        bdq_cell u_cell (
            .i_clk     (i_clk),
            .i_sel     (w_sel[g]),
            .i_left    (w_value[(g + DEPTH - 1) % DEPTH]),
            .i_right   (w_value[(g + 1) % DEPTH]),
            .i_operand (w_cell_operand),
            .o_value   (w_value[g]),
            .o_match   (w_match[g])
        );
    end

    // Marks every cell at or beyond the first occupied matching one: those cells take
    // their right neighbour's entry, which removes the first match and keeps the order.
    always_comb begin
        logic run;
        run = 1'b0;
        for (int k = 0; k < DEPTH; k++) begin
            run         = run || (w_match[k] && (CNT_W'(k) < r_count));
            w_prefix[k] = run;
        end
        w_any_del = run;
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && !w_empty) begin
                    if (w_mode == MODE_MAX) begin
                        n_state = S_MAX;
                    end else if (w_mode == MODE_DELETE) begin
                        n_state = S_DEL;
                    end
                end
            end
            S_MAX: begin
                if (w_scan_last) begin
                    n_state = S_FIN;
                end
            end
            S_DEL: begin
                if (!w_any_del) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    // Datapath and output logic of the sequencer.
    always_comb begin
        logic signed [DATA_W-1:0] res_data;
        t_status                  res_status;
        logic                     res_now;

        n_count     = r_count;
        n_step      = r_step;
        n_acc       = r_acc;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        res_data    = '0;
        res_status  = ST_OK;
        res_now     = 1'b1;
        for (int k = 0; k < DEPTH; k++) begin
            w_sel[k] = SEL_HOLD;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (w_mode)
                        MODE_PUSH_BACK: begin
                            if (w_full) begin
                                res_status = ST_FULL;
                            end else begin
                                for (int k = 0; k < DEPTH; k++) begin
                                    if (CNT_W'(k) == r_count) begin
                                        w_sel[k] = SEL_OPERAND;
                                    end
                                end
                                n_count = r_count + 1'b1;
                            end
                        end
                        MODE_PUSH_FRONT: begin
                            if (w_full) begin
                                res_status = ST_FULL;
                            end else begin
                                for (int k = 0; k < DEPTH; k++) begin
                                    w_sel[k] = (k == 0) ? SEL_OPERAND : SEL_LEFT;
                                end
                                n_count = r_count + 1'b1;
                            end
                        end
                        MODE_POP_FRONT: begin
                            if (w_empty) begin
                                res_status = ST_EMPTY;
                            end else begin
                                res_data = w_value[0];
                                for (int k = 0; k < DEPTH; k++) begin
                                    w_sel[k] = SEL_RIGHT;
                                end
                                n_count = r_count - 1'b1;
                            end
                        end
                        MODE_POP_BACK: begin
                            if (w_empty) begin
                                res_status = ST_EMPTY;
                            end else begin
                                res_data = w_value[IDX_W'(r_count - 1'b1)];
                                n_count  = r_count - 1'b1;
                            end
                        end
                        MODE_DELETE, MODE_MAX: begin
                            if (w_empty) begin
                                res_status = ST_EMPTY;
                            end else begin
                                res_now = 1'b0;
                                n_step  = '0;
                                n_acc   = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (res_now) begin
                        n_out_valid     = 1'b1;
                        n_out.data      = res_data;
                        n_out.status    = res_status;
                        n_out.occupancy = OCC_W'(n_count);
                    end
                end
            end
            S_MAX: begin
                for (int k = 0; k < DEPTH; k++) begin
                    w_sel[k] = SEL_RIGHT;
                end
                if (CNT_W'(r_step) < r_count) begin
                    if ((r_step == '0) || (w_value[0] > r_acc)) begin
                        n_acc = w_value[0];
                    end
                end
                n_step = w_scan_last ? '0 : r_step + 1'b1;
            end
            S_DEL: begin
                for (int k = 0; k < DEPTH; k++) begin
                    if (w_prefix[k]) begin
                        w_sel[k] = SEL_RIGHT;
                    end
                end
                if (w_any_del) begin
                    n_count = r_count - 1'b1;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.data      = r_acc;
                    n_out.status    = ST_OK;
                    n_out.occupancy = OCC_W'(r_count);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_operand <= i_in_data.operand;
        end
        r_acc <= n_acc;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The store never holds more than DEPTH entries.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("occupancy above depth");

    // A delete scan never lengthens the store.
    a_del_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEL) |=> (r_count <= $past(r_count)))
        else $error("delete scan grew the store");

    // A maximum scan is only ever running on a non-empty store.
    a_max_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAX) |-> (r_count != '0))
        else $error("maximum scan on empty store");

    // No result is produced by the scan states themselves.
    a_scan_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_MAX) || (r_state == S_DEL)) && !r_out_valid |=> !r_out_valid)
        else $error("result produced during scan");

endmodule

// ===== bench/tb_bounded_deque_with_delete.sv =====
// Self-checking testbench for the bounded deque with delete-by-value.
module tb_bounded_deque_with_delete;

    import bdq_pkg::*;

    // Mode codes that the block must treat as a no-operation.
    localparam logic [MODE_W-1:0] MODE_UNUSED_A = 3'd6;
    localparam logic [MODE_W-1:0] MODE_UNUSED_B = 3'd7;

    localparam logic signed [DATA_W-1:0] VAL_MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] VAL_MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};

    // The limit leaves a wide margin over the slowest correct run.
    localparam int CYCLE_LIMIT = 200_000;

    // The random traffic is split into phases that lean towards filling the store,
    // draining it, or an even mix, so that both the full and the empty corners are
    // reached many times over.
    typedef enum logic [1:0] {
        PHASE_FILL,
        PHASE_DRAIN,
        PHASE_MIXED
    } t_phase;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    t_in_item   in_item;
    logic       out_valid;
    logic       out_stall;
    t_out_item  out_item;

    // Our own copy of the store, front entry first, and the answers still owed by the block.
    logic signed [DATA_W-1:0] model_entries [$];
    t_out_item                expected_results [$];

    // A handful of recurring values, so that deletions find matches and maxima tie.
    logic signed [DATA_W-1:0] value_pool [8];

    bit idle_enable;
    int fail_count;
    int cycle_count;
    int mode_count [8];
    int full_answers;
    int empty_answers;
    int stall_left;

    bounded_deque_with_delete DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_item)
    );

    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return value_pool[$urandom_range(0, 7)];
        if (r < 60)
            return $urandom_range(0, 16) - 8;
        if (r < 70)
            return ($urandom_range(0, 1) != 0) ? VAL_MOST_POS : VAL_MOST_NEG;
        return $urandom();
    endfunction

    // A deletion usually names a value that is really stored, otherwise it rarely matches.
    function automatic logic signed [DATA_W-1:0] pick_delete_operand();
        if (model_entries.size() != 0 && $urandom_range(0, 99) < 70)
            return model_entries[$urandom_range(0, model_entries.size() - 1)];
        return pick_value();
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode(input t_phase phase);
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            return ($urandom_range(0, 1) != 0) ? MODE_UNUSED_A : MODE_UNUSED_B;
        r = $urandom_range(0, 99);
        case (phase)
            PHASE_FILL: begin
                if (r < 45) return MODE_PUSH_BACK;
                if (r < 85) return MODE_PUSH_FRONT;
                if (r < 90) return MODE_POP_FRONT;
                if (r < 94) return MODE_POP_BACK;
                if (r < 97) return MODE_DELETE;
                return MODE_MAX;
            end
            PHASE_DRAIN: begin
                if (r < 5)  return MODE_PUSH_BACK;
                if (r < 10) return MODE_PUSH_FRONT;
                if (r < 40) return MODE_POP_FRONT;
                if (r < 70) return MODE_POP_BACK;
                if (r < 90) return MODE_DELETE;
                return MODE_MAX;
            end
            default: begin
                if (r < 20) return MODE_PUSH_BACK;
                if (r < 38) return MODE_PUSH_FRONT;
                if (r < 53) return MODE_POP_FRONT;
                if (r < 68) return MODE_POP_BACK;
                if (r < 84) return MODE_DELETE;
                return MODE_MAX;
            end
        endcase
    endfunction

    // Applies one operation to our copy of the store and returns the answer the block
    // owes for it. The store is kept as a plain queue, front first, so the shifting
    // of the cell row in the hardware plays no part here.
    function automatic t_out_item deque_apply(input logic [MODE_W-1:0] mode,
                                              input logic signed [DATA_W-1:0] operand);
        t_out_item                res;
        logic signed [DATA_W-1:0] kept [$];
        logic signed [DATA_W-1:0] largest;
        res.data   = '0;
        res.status = ST_OK;
        case (mode)
            MODE_PUSH_BACK: begin
                if (model_entries.size() >= DEPTH)
                    res.status = ST_FULL;
                else
                    model_entries.push_back(operand);
            end
            MODE_PUSH_FRONT: begin
                if (model_entries.size() >= DEPTH)
                    res.status = ST_FULL;
                else
                    model_entries.push_front(operand);
            end
            MODE_POP_FRONT: begin
                if (model_entries.size() == 0)
                    res.status = ST_EMPTY;
                else
                    res.data = model_entries.pop_front();
            end
            MODE_POP_BACK: begin
                if (model_entries.size() == 0)
                    res.status = ST_EMPTY;
                else
                    res.data = model_entries.pop_back();
            end
            MODE_DELETE: begin
                // Every matching entry goes; the rest keep their order.
                if (model_entries.size() == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    foreach (model_entries[k])
                        if (model_entries[k] != operand)
                            kept.push_back(model_entries[k]);
                    model_entries = kept;
                end
            end
            MODE_MAX: begin
                if (model_entries.size() == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    largest = model_entries[0];
                    foreach (model_entries[k])
                        if (model_entries[k] > largest)
                            largest = model_entries[k];
                    res.data = largest;
                end
            end
            default: ;
        endcase
        res.occupancy = OCC_W'(model_entries.size());
        return res;
    endfunction

    // Offers one transaction, after a random gap when idling is on, and holds it steady
    // until the block takes it. The expected answer is recorded at the accepting edge.
    // Entered and left at a falling edge.
    task automatic send_op(input logic [MODE_W-1:0] mode,
                           input logic signed [DATA_W-1:0] operand);
        int gap;
        gap = idle_enable ? pick_gap() : 0;
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item.mode    = mode;
        in_item.operand = operand;
        in_valid        = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        expected_results.push_back(deque_apply(mode, operand));
        mode_count[mode]++;
        @(negedge clk);
    endtask

    // Every operation that needs entries, asked of an empty store.
    task automatic test_empty_store();
        send_op(MODE_POP_FRONT, 32'sd11);
        send_op(MODE_POP_BACK, 32'sd12);
        send_op(MODE_DELETE, 32'sd0);
        send_op(MODE_MAX, 32'sd0);
    endtask

    // Fills the store from both ends with extreme values, bit patterns that set every
    // operand bit both ways, and one value stored three times for the deletion test.
    task automatic test_fill_to_capacity();
        logic signed [DATA_W-1:0] fill_values [16];
        fill_values = '{VAL_MOST_NEG, VAL_MOST_POS, 32'sd0, -32'sd1, 32'sd42, 32'sd42,
                        32'sd1, -32'sd2, 32'sd42, 32'sh5555_5555, 32'shAAAA_AAAA,
                        32'sd1000, -32'sd1000, 32'sd7, -32'sd7, 32'sd3};
        for (int k = 0; k < 16; k++)
            send_op(k[0] ? MODE_PUSH_FRONT : MODE_PUSH_BACK, fill_values[k]);
    endtask

    // Pushes at either end of a full store are dropped; the maximum spans every entry.
    task automatic test_full_store();
        send_op(MODE_PUSH_BACK, 32'sd9);
        send_op(MODE_PUSH_FRONT, 32'sd9);
        send_op(MODE_MAX, 32'sd0);
    endtask

    // Deletion of several copies, deletion that finds nothing, and the unused modes.
    task automatic test_delete_and_unused();
        send_op(MODE_DELETE, 32'sd42);
        send_op(MODE_DELETE, 32'sd12345);
        send_op(MODE_UNUSED_A, 32'sd5);
        send_op(MODE_UNUSED_B, -32'sd5);
    endtask

    // Random traffic in phases of forty transactions. Each phase picks its leaning and
    // whether the two sides idle at all, so that back-to-back stretches occur as well.
    task automatic test_random_traffic(input int n_items);
        t_phase                   phase;
        logic [MODE_W-1:0]        mode;
        logic signed [DATA_W-1:0] operand;
        phase = PHASE_MIXED;
        for (int n = 0; n < n_items; n++) begin
            if (n % 40 == 0) begin
                phase       = t_phase'($urandom_range(0, 2));
                idle_enable = ($urandom_range(0, 3) != 0);
            end
            mode    = pick_mode(phase);
            operand = (mode == MODE_DELETE) ? pick_delete_operand() : pick_value();
            send_op(mode, operand);
        end
    endtask

    // The receiver stalls in random bursts while idling is on, and never otherwise.
    initial begin
        out_stall  = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (!idle_enable)
                stall_left = 0;
            else if (stall_left == 0 && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            out_stall = (stall_left != 0);
            if (stall_left != 0)
                stall_left--;
        end
    end

    // Each answer taken from the block is held against the oldest one still owed.
    always @(posedge clk) begin : check_results
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result with none expected: data %0d status %0d occupancy %0d",
                       $signed(out_item.data), out_item.status, out_item.occupancy);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (out_item.data !== want.data) begin
                    $error("data mismatch: expected %0d, actual %0d",
                           $signed(want.data), $signed(out_item.data));
                    fail_count++;
                end
                if (out_item.status !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, out_item.status);
                    fail_count++;
                end
                if (out_item.occupancy !== want.occupancy) begin
                    $error("occupancy mismatch: expected %0d, actual %0d",
                           want.occupancy, out_item.occupancy);
                    fail_count++;
                end
                if (want.status == ST_FULL)
                    full_answers++;
                if (want.status == ST_EMPTY)
                    empty_answers++;
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("run stopped after %0d cycles with %0d results outstanding",
                   cycle_count, expected_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_item     = '0;
        idle_enable = 1'b1;
        fail_count  = 0;
        cycle_count = 0;
        full_answers  = 0;
        empty_answers = 0;
        foreach (mode_count[m])
            mode_count[m] = 0;
        foreach (value_pool[k])
            value_pool[k] = $urandom();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_store();
        test_fill_to_capacity();
        test_full_store();
        test_delete_and_unused();
        test_random_traffic(400);

        // Stop offering work and let the receiver run freely until every answer is in,
        // then allow for the longest scan in case anything further turns up.
        in_valid    = 1'b0;
        idle_enable = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (2 * DEPTH + 8) @(posedge clk);

        $display("Covered %0d pushes back, %0d pushes front, %0d pops front, %0d pops back,",
                 mode_count[MODE_PUSH_BACK], mode_count[MODE_PUSH_FRONT],
                 mode_count[MODE_POP_FRONT], mode_count[MODE_POP_BACK]);
        $display("%0d deletions, %0d maxima, %0d unused modes; %0d full and %0d empty answers.",
                 mode_count[MODE_DELETE], mode_count[MODE_MAX],
                 mode_count[MODE_UNUSED_A] + mode_count[MODE_UNUSED_B],
                 full_answers, empty_answers);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/bdq_pkg.sv
rtl/core/bdq_cell.sv
rtl/core/bounded_deque_with_delete.sv
bench/tb_bounded_deque_with_delete.sv
